// ===== src/dmwbc_pkg.sv =====
`timescale 1ns / 1ps

package dmwbc_pkg;

    // geometry (all counts are powers of two)
    localparam int NUM_SETS       = 4;
    localparam int WORDS_PER_LINE = 4;
    localparam int MEMORY_WORDS   = 256;

    localparam int ADDR_W = 8;
    localparam int DATA_W = 32;

    localparam int LINE_WORDS = NUM_SETS * WORDS_PER_LINE;
    localparam int OFF_W      = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int TAG_BITS   = ADDR_W - $clog2(LINE_WORDS);
    localparam int TAG_W      = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int LINE_AW    = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int MEM_AW     = $clog2(MEMORY_WORDS);

    localparam logic [DATA_W-1:0] MEM_INIT_MARK = 32'hA000_0000;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture a new request
        logic access;    // hit access on the line buffer
        logic wb_rd;     // read victim word from line buffer
        logic wb_wr;     // write victim word to backing memory
        logic fill_rd;   // read fill word from backing memory
        logic fill_wr;   // write fill word into line buffer
        logic install;   // update tag, valid, dirty with the last fill word
        logic respond;   // result on the ports
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic victim_dirty;
        logic last_word;
    } dp_status_t;

endpackage

// ===== src/direct_mapped_writeback_cache.sv =====
`timescale 1ns / 1ps

// Direct-mapped write-back, write-allocate cache with its own word-addressed
// backing memory. A transaction is taken when start is high and busy is low;
// its result appears on read_data, hit and wrote_back for exactly one cycle
// while done is high, and the receiver cannot stall it, so capture it then.
// A hit goes from the tag lookup, then the registered line buffer read, to
// done. A clean miss first fills the line (one backing memory read and one
// line buffer write per word) and then does a second lookup, and a dirty
// miss first writes the victim back (one line buffer read and one backing
// memory write per word); each memory has a single port. A new
// transaction may be accepted in the cycle that done is high.
module direct_mapped_writeback_cache
    import dmwbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              command,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    output logic              done,
    output logic [DATA_W-1:0] read_data,
    output logic              hit,
    output logic              wrote_back
);

    // command and status between the controller and the datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: lookup, then on a miss an optional write-back, a fill and a final access
    dmwbc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // tags, valid and dirty bits, line buffer and backing memory
    dmwbc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .status     (status),
        .read_data  (read_data),
        .hit        (hit),
        .wrote_back (wrote_back)
    );

endmodule

// ===== src/dmwbc_ram.sv =====
`timescale 1ns / 1ps

module dmwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dmwbc_ctrl.sv =====
`timescale 1ns / 1ps

module dmwbc_ctrl
    import dmwbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WB_RD,
        ST_WB_WR,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_RESPOND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (status.hit)
                begin
                    state_next = ST_RESPOND;
                end
                else if (status.victim_dirty)
                begin
                    state_next = ST_WB_RD;
                end
                else
                begin
                    state_next = ST_FILL_RD;
                end
            end
            ST_WB_RD:
            begin
                state_next = ST_WB_WR;
            end
            ST_WB_WR:
            begin
                state_next = status.last_word ? ST_FILL_RD : ST_WB_RD;
            end
            ST_FILL_RD:
            begin
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                state_next = status.last_word ? ST_LOOKUP : ST_FILL_RD;
            end
            ST_RESPOND:
            begin
                state_next = accept ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE) && (state_next != ST_RESPOND);
            done_reg  <= (state_next == ST_RESPOND);
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.load    = accept;
        cmd.access  = (state_reg == ST_LOOKUP) && status.hit;
        cmd.wb_rd   = (state_reg == ST_WB_RD);
        cmd.wb_wr   = (state_reg == ST_WB_WR);
        cmd.fill_rd = (state_reg == ST_FILL_RD);
        cmd.fill_wr = (state_reg == ST_FILL_WR);
        cmd.install = (state_reg == ST_FILL_WR) && status.last_word;
        cmd.respond = done_reg;
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg && state_reg == ST_IDLE) |=> busy_reg)
        else $error("accepted transaction did not raise busy");

    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_LOOKUP && status.hit))
        else $error("result without a hit lookup");

    a_fill_before_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB_WR && status.last_word) |=> state_reg == ST_FILL_RD)
        else $error("write-back not followed by fill");

endmodule

// ===== src/dmwbc_datapath.sv =====
`timescale 1ns / 1ps

module dmwbc_datapath
    import dmwbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  logic              command,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    output dp_status_t        status,
    output logic [DATA_W-1:0] read_data,
    output logic              hit,
    output logic              wrote_back
);

    // request registers
    logic              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [OFF_W-1:0]  cnt_reg;
    logic [OFF_W-1:0]  cnt_next;
    logic              miss_reg;
    logic              wb_reg;

    // line state
    logic [NUM_SETS-1:0] valid_reg;
    logic [NUM_SETS-1:0] dirty_reg;
    logic [TAG_W-1:0]    tag_reg [NUM_SETS];

    // backing memory written marks
    logic [MEMORY_WORDS-1:0] mem_written_reg;
    logic                    fill_valid_reg;
    logic [MEM_AW-1:0]       fill_idx_reg;

    logic [OFF_W-1:0]   off;
    logic [SET_W-1:0]   set_idx;
    logic [TAG_W-1:0]   tag;
    logic [LINE_AW-1:0] slot;
    logic [LINE_AW-1:0] set_word;
    logic [31:0]        victim_base;
    logic [31:0]        fill_base;
    logic [MEM_AW-1:0]  victim_idx;
    logic [MEM_AW-1:0]  fill_idx;
    logic [DATA_W-1:0]  fill_word;

    logic [LINE_AW-1:0] line_addr;
    logic               line_we;
    logic [DATA_W-1:0]  line_wdata;
    logic [DATA_W-1:0]  line_rdata;
    logic [MEM_AW-1:0]  mem_addr;
    logic               mem_we;
    logic [DATA_W-1:0]  mem_rdata;

    assign off     = OFF_W'(addr_reg % WORDS_PER_LINE);
    assign set_idx = SET_W'((addr_reg / WORDS_PER_LINE) % NUM_SETS);
    assign tag     = TAG_W'(addr_reg / LINE_WORDS);

    assign slot     = LINE_AW'(32'(set_idx) * WORDS_PER_LINE + 32'(off));
    assign set_word = LINE_AW'(32'(set_idx) * WORDS_PER_LINE + 32'(cnt_reg));

    assign victim_base = (32'(tag_reg[set_idx]) * NUM_SETS + 32'(set_idx)) * WORDS_PER_LINE
                         + 32'(cnt_reg);
    assign fill_base   = (32'(tag) * NUM_SETS + 32'(set_idx)) * WORDS_PER_LINE + 32'(cnt_reg);
    assign victim_idx  = victim_base[MEM_AW-1:0];
    assign fill_idx    = fill_base[MEM_AW-1:0];

    // never-written memory words read as their reset pattern
    assign fill_word = fill_valid_reg ? mem_rdata : (MEM_INIT_MARK | DATA_W'(fill_idx_reg));

    always_comb
    begin
        line_addr  = slot;
        line_we    = 1'b0;
        line_wdata = wdata_reg;
        if (cmd.access)
        begin
            line_we = (cmd_reg == CMD_WRITE);
        end
        else if (cmd.wb_rd)
        begin
            line_addr = set_word;
        end
        else if (cmd.fill_wr)
        begin
            line_addr  = set_word;
            line_we    = 1'b1;
            line_wdata = fill_word;
        end
    end

    assign mem_addr = cmd.wb_wr ? victim_idx : fill_idx;
    assign mem_we   = cmd.wb_wr;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (cmd.wb_wr || cmd.fill_wr)
        begin
            cnt_next = status.last_word ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= command;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        if (cmd.install)
        begin
            tag_reg[set_idx] <= tag;
        end
        if (cmd.fill_rd)
        begin
            fill_idx_reg <= fill_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            miss_reg        <= 1'b0;
            wb_reg          <= 1'b0;
            valid_reg       <= '0;
            dirty_reg       <= '0;
            mem_written_reg <= '0;
            fill_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.load)
            begin
                miss_reg <= 1'b0;
                wb_reg   <= 1'b0;
            end
            if (cmd.wb_wr)
            begin
                wb_reg                    <= 1'b1;
                mem_written_reg[mem_addr] <= 1'b1;
            end
            if (cmd.fill_rd)
            begin
                fill_valid_reg <= mem_written_reg[fill_idx];
            end
            if (cmd.install)
            begin
                miss_reg           <= 1'b1;
                valid_reg[set_idx] <= 1'b1;
                dirty_reg[set_idx] <= 1'b0;
            end
            if (cmd.access && cmd_reg == CMD_WRITE)
            begin
                dirty_reg[set_idx] <= 1'b1;
            end
        end
    end

    dmwbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINE_WORDS)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .addr  (line_addr),
        .wdata (line_wdata),
        .rdata (line_rdata)
    );

    dmwbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_WORDS)
    ) u_backing_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (line_rdata),
        .rdata (mem_rdata)
    );

    assign status.hit          = valid_reg[set_idx] && (tag_reg[set_idx] == tag);
    assign status.victim_dirty = valid_reg[set_idx] && dirty_reg[set_idx];
    assign status.last_word    = (cnt_reg == OFF_W'(WORDS_PER_LINE - 1));

    assign read_data  = (cmd_reg == CMD_WRITE) ? '0 : line_rdata;
    assign hit        = !miss_reg;
    assign wrote_back = wb_reg;

    a_wb_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb_wr |-> (valid_reg[set_idx] && dirty_reg[set_idx]))
        else $error("write-back of a clean or invalid line");

    a_respond_resident: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |-> (valid_reg[set_idx] && tag_reg[set_idx] == tag))
        else $error("result from a line that does not hold the address");

    a_install_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.install |-> !status.hit)
        else $error("line refilled on a hit");

endmodule

// ===== test/tb_direct_mapped_writeback_cache.sv =====
`timescale 1ns / 1ps

module tb_direct_mapped_writeback_cache
    import dmwbc_pkg::*;
();

    // expected outcome of one cache transaction
    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              hit;
        logic              wrote_back;
    } access_outcome_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              done;
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              wrote_back;

    direct_mapped_writeback_cache uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .address    (address),
        .write_data (write_data),
        .done       (done),
        .read_data  (read_data),
        .hit        (hit),
        .wrote_back (wrote_back)
    );

    // shadow copy of the cache and its backing memory
    logic              shadow_valid [NUM_SETS];
    logic              shadow_dirty [NUM_SETS];
    int unsigned       shadow_tag   [NUM_SETS];
    logic [DATA_W-1:0] shadow_words [LINE_WORDS];
    logic [DATA_W-1:0] shadow_memory[MEMORY_WORDS];

    // outcomes of accepted transactions, oldest first
    access_outcome_t pending_outcomes[$];
    access_outcome_t oldest_outcome;

    int error_count;
    int read_count;
    int write_count;
    int hit_count;
    int miss_count;
    int writeback_count;
    int no_gap_run;

    // 8 ns clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // shadow state after reset: lines invalid and clean, memory holds its marks
    function automatic void reset_shadow();
        for (int s = 0; s < NUM_SETS; s++)
        begin
            shadow_valid[s] = 1'b0;
            shadow_dirty[s] = 1'b0;
            shadow_tag[s]   = 0;
        end
        for (int i = 0; i < LINE_WORDS; i++)
            shadow_words[i] = '0;
        for (int i = 0; i < MEMORY_WORDS; i++)
            shadow_memory[i] = MEM_INIT_MARK | DATA_W'(i);
    endfunction

    // one cache access on the shadow state
    function automatic access_outcome_t model_cache_access(
        input logic              cmd,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] wdata
    );
        access_outcome_t outcome;
        int unsigned off;
        int unsigned set_idx;
        int unsigned tag;
        int unsigned victim_base;
        int unsigned fill_base;
        off     = addr % WORDS_PER_LINE;
        set_idx = (addr / WORDS_PER_LINE) % NUM_SETS;
        tag     = addr / (WORDS_PER_LINE * NUM_SETS);
        outcome.read_data  = '0;
        outcome.wrote_back = 1'b0;
        outcome.hit        = shadow_valid[set_idx] && (shadow_tag[set_idx] == tag);
        if (!outcome.hit)
        begin
            // dirty victim goes back to memory first
            if (shadow_valid[set_idx] && shadow_dirty[set_idx])
            begin
                victim_base = (shadow_tag[set_idx] * NUM_SETS + set_idx) * WORDS_PER_LINE;
                for (int w = 0; w < WORDS_PER_LINE; w++)
                    shadow_memory[(victim_base + w) % MEMORY_WORDS] =
                        shadow_words[set_idx * WORDS_PER_LINE + w];
                outcome.wrote_back = 1'b1;
            end
            // then the line is filled from memory
            fill_base = (tag * NUM_SETS + set_idx) * WORDS_PER_LINE;
            for (int w = 0; w < WORDS_PER_LINE; w++)
                shadow_words[set_idx * WORDS_PER_LINE + w] =
                    shadow_memory[(fill_base + w) % MEMORY_WORDS];
            shadow_tag[set_idx]   = tag;
            shadow_valid[set_idx] = 1'b1;
            shadow_dirty[set_idx] = 1'b0;
        end
        if (cmd == CMD_WRITE)
        begin
            shadow_words[set_idx * WORDS_PER_LINE + off] = wdata;
            shadow_dirty[set_idx] = 1'b1;
        end
        else
        begin
            outcome.read_data = shadow_words[set_idx * WORDS_PER_LINE + off];
        end
        return outcome;
    endfunction

    // send one transaction; called at a rising edge, returns at the accepting edge
    // start stays high on return so that back-to-back transactions need no extra step
    task automatic issue_request(
        input logic              cmd,
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] wdata
    );
        int gap;
        // idle gap: runs of back-to-back traffic alternate with random pauses
        if (no_gap_run > 0)
        begin
            no_gap_run--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 15) == 0)
                no_gap_run = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        address    <= addr;
        write_data <= wdata;
        // accepted at the first edge with start high and busy low
        do
            @(posedge clk);
        while (busy);
        pending_outcomes.push_back(model_cache_access(cmd, addr, wdata));
    endtask

    // result checker: done marks a single-cycle result that cannot be stalled
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no transaction outstanding: read_data %h hit %b wrote_back %b",
                       read_data, hit, wrote_back);
                error_count++;
            end
            else
            begin
                oldest_outcome = pending_outcomes.pop_front();
                if (read_data !== oldest_outcome.read_data)
                begin
                    $error("read_data: expected %h, got %h", oldest_outcome.read_data, read_data);
                    error_count++;
                end
                if (hit !== oldest_outcome.hit)
                begin
                    $error("hit: expected %b, got %b", oldest_outcome.hit, hit);
                    error_count++;
                end
                if (wrote_back !== oldest_outcome.wrote_back)
                begin
                    $error("wrote_back: expected %b, got %b",
                           oldest_outcome.wrote_back, wrote_back);
                    error_count++;
                end
                if (oldest_outcome.hit)
                    hit_count++;
                else
                    miss_count++;
                if (oldest_outcome.wrote_back)
                    writeback_count++;
            end
        end
    end

    // count commands as they are handed over
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            if (command == CMD_WRITE)
                write_count++;
            else
                read_count++;
        end
    end

    // word address built from its tag, set index and word offset
    function automatic logic [ADDR_W-1:0] compose_address(
        input int unsigned tag,
        input int unsigned set_idx,
        input int unsigned off
    );
        return ADDR_W'((tag * NUM_SETS + set_idx) * WORDS_PER_LINE + off);
    endfunction

    // random data, weighted toward all-zero and all-one words now and then
    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // hand-picked transactions: address and data extremes, clean and dirty misses,
    // write misses, write-back of a written line and refill of the written data
    task automatic test_directed_cases();
        issue_request(CMD_READ,  8'h00, 32'h0000_0000);  // cold miss, clean
        issue_request(CMD_READ,  8'h00, 32'hFFFF_FFFF);  // hit, data ignored
        issue_request(CMD_WRITE, 8'h03, 32'hFFFF_FFFF);  // write hit dirties set 0
        issue_request(CMD_READ,  8'h03, 32'h0000_0000);  // read back the write
        issue_request(CMD_WRITE, 8'hFF, 32'h0000_0000);  // write miss, top address
        issue_request(CMD_READ,  8'hFF, 32'h0000_0000);  // hit on zero word
        issue_request(CMD_READ,  8'h40, 32'h0000_0000);  // conflict, dirty victim
        issue_request(CMD_READ,  8'h03, 32'h0000_0000);  // refill sees written word
        issue_request(CMD_WRITE, 8'hAA, 32'hAAAA_AAAA);  // alternating bits
        issue_request(CMD_WRITE, 8'h55, 32'h5555_5555);
        issue_request(CMD_READ,  8'hAA, 32'h0000_0000);
        issue_request(CMD_READ,  8'h55, 32'h0000_0000);
        issue_request(CMD_WRITE, 8'h9A, 32'h1234_5678);  // dirty victim on a write miss
        issue_request(CMD_READ,  8'hAA, 32'h0000_0000);  // dirty victim, old data returns
        issue_request(CMD_READ,  8'hF0, 32'h0000_0000);  // top tag on set 0
        issue_request(CMD_WRITE, 8'h0F, 32'hDEAD_BEEF);  // evicts dirty top-tag line
        issue_request(CMD_READ,  8'hFF, 32'h0000_0000);  // reload of written-back zero
        issue_request(CMD_READ,  8'h0F, 32'h0000_0000);  // refill returns the evicted write
    endtask

    // small working set per set: mostly hits, with write then read-back pairs
    task automatic test_hot_working_set(input int count);
        int unsigned tag_base;
        int unsigned tag;
        int unsigned set_idx;
        logic [ADDR_W-1:0] addr;
        logic cmd;
        tag_base = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                tag_base = $urandom_range(0, (1 << TAG_W) - 2);
            set_idx = $urandom_range(0, NUM_SETS - 1);
            tag     = tag_base + $urandom_range(0, 1);
            addr    = compose_address(tag, set_idx, $urandom_range(0, WORDS_PER_LINE - 1));
            if ($urandom_range(0, 9) == 0)
                addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
            cmd = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
            issue_request(cmd, addr, pick_data());
            // read back the word just written
            if (cmd == CMD_WRITE && $urandom_range(0, 3) == 0)
            begin
                issue_request(CMD_READ, addr, $urandom);
                i++;
            end
        end
    endtask

    // whole address space, write heavy: conflict misses and frequent write-backs
    task automatic test_conflict_thrash(input int count);
        logic cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(0, 4) < 3) ? CMD_WRITE : CMD_READ;
            issue_request(cmd, ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1)), pick_data());
        end
    endtask

    // stop sending and let the outstanding results drain
    task automatic drain_results();
        int waited;
        @(posedge clk);
        start <= 1'b0;
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_outcomes.size() != 0)
        begin
            $error("%0d transactions never returned a result", pending_outcomes.size());
            error_count += pending_outcomes.size();
        end
        // then wait so that any stray result shows up
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        // all inputs known from time zero
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_READ;
        address    = '0;
        write_data = '0;
        error_count     = 0;
        read_count      = 0;
        write_count     = 0;
        hit_count       = 0;
        miss_count      = 0;
        writeback_count = 0;
        no_gap_run      = 0;
        reset_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_hot_working_set(900);
        test_conflict_thrash(900);
        drain_results();

        $display("covered %0d reads and %0d writes: %0d hits, %0d misses, %0d dirty write-backs",
                 read_count, write_count, hit_count, miss_count, writeback_count);
        $display("%0d field mismatches or protocol errors", error_count);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("timeout waiting for the cache to respond");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
